// ----- design/descending_sorted_list_top_macros.svh -----
// Assertion macros for the descending sorted list.
// Included by descending_sorted_list_top; the including module provides clk and rst_n.
`ifndef DESCENDING_SORTED_LIST_TOP_MACROS_SVH
`define DESCENDING_SORTED_LIST_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define DSL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define DSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DSL_ASSERT_SAME(label, ante, cons, msg)
`define DSL_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- design/dsl_pkg.sv -----
// Shared types and constants for the descending sorted list.
// No dependencies.
`default_nettype none
package dsl_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);

  typedef logic signed [31:0] word_t;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_DELETE   = 2'd1,
    CMD_TRAVERSE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_TRAV
  } state_t;

  typedef struct packed {
    logic [1:0] cmd;
    word_t      value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] status;
    word_t      item;
    logic       last;
  } out_beat_t;

  // Broadcast to every cell.
  typedef struct packed {
    logic  ins;
    logic  del;
    word_t value;
  } cell_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic found;
  } chain_stat_t;

endpackage
`default_nettype wire

// ----- design/dsl_cell.sv -----
// One list slot: entry register, valid bit, compare against the broadcast value.
// Depends on dsl_pkg.
`default_nettype none
module dsl_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire dsl_pkg::cell_ctrl_t ctrl,
  input  wire logic                found,
  input  wire logic                left_gt,
  input  wire logic                left_valid,
  input  wire dsl_pkg::word_t      left_data,
  input  wire logic                right_valid,
  input  wire dsl_pkg::word_t      right_data,
  output dsl_pkg::word_t           data,
  output logic                     valid,
  output logic                     gt,
  output logic                     match
);

  dsl_pkg::word_t data_r, data_nxt;
  logic           valid_r, valid_nxt;

  assign gt    = valid_r && (data_r > ctrl.value);
  assign match = valid_r && (data_r == ctrl.value);
  assign data  = data_r;
  assign valid = valid_r;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (ctrl.ins && !gt) begin
      data_nxt  = left_gt ? ctrl.value : left_data;
      valid_nxt = valid_r | left_valid;
    end else if (ctrl.del && found) begin
      valid_nxt = right_valid;
      if (!gt) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/dsl_chain.sv -----
// Row of list cells with neighbor links, global hit flag and traverse read port.
// Depends on dsl_pkg and dsl_cell.
`default_nettype none
module dsl_chain (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire dsl_pkg::cell_ctrl_t         ctrl,
  input  wire logic [dsl_pkg::IDX_W-1:0]   rd_idx,
  output dsl_pkg::chain_stat_t             stat,
  output logic [dsl_pkg::DEPTH-1:0]        vld,
  output dsl_pkg::word_t                   rd_data,
  output logic                             rd_last
);

  dsl_pkg::word_t             data_w [dsl_pkg::DEPTH];
  logic [dsl_pkg::DEPTH-1:0]  gt_w;
  logic [dsl_pkg::DEPTH-1:0]  match_w;
  logic [dsl_pkg::DEPTH-1:0]  vld_after;
  logic                       found;

  assign found = |match_w;

  for (genvar i = 0; i < dsl_pkg::DEPTH; i++) begin : g_cell
    logic           l_gt, l_valid, r_valid;
    dsl_pkg::word_t l_data, r_data;

    if (i == 0) begin : g_head
      assign l_gt    = 1'b1;
      assign l_valid = 1'b1;
      assign l_data  = ctrl.value;
    end else begin : g_body
      assign l_gt    = gt_w[i-1];
      assign l_valid = vld[i-1];
      assign l_data  = data_w[i-1];
    end

    if (i == dsl_pkg::DEPTH - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_data  = data_w[i];
    end else begin : g_mid
      assign r_valid = vld[i+1];
      assign r_data  = data_w[i+1];
    end

    dsl_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .found       (found),
      .left_gt     (l_gt),
      .left_valid  (l_valid),
      .left_data   (l_data),
      .right_valid (r_valid),
      .right_data  (r_data),
      .data        (data_w[i]),
      .valid       (vld[i]),
      .gt          (gt_w[i]),
      .match       (match_w[i])
    );
  end

  assign vld_after  = {1'b0, vld[dsl_pkg::DEPTH-1:1]};
  assign rd_data    = data_w[rd_idx];
  assign rd_last    = !vld_after[rd_idx];

  assign stat.full  = vld[dsl_pkg::DEPTH-1];
  assign stat.empty = !vld[0];
  assign stat.found = found;

endmodule
`default_nettype wire

// ----- design/descending_sorted_list_top.sv -----
// Top level of the descending sorted list: command decode, traverse sequencer, output register.
// Depends on dsl_pkg, dsl_chain and descending_sorted_list_top_macros.svh.
//
//   channel  ports                      payload
//   in       in_valid/in_ready/in_data   dsl_pkg::in_beat_t  (cmd, value)
//   out      out_valid/out_ready/out_data dsl_pkg::out_beat_t (status, item, last)
//
// Insert and delete: all cells update in parallel. Unused codes are accepted and give no output beat.
// Traverse: one beat per entry while the output register is free, read through the chain's index mux;
// an empty list gives a single beat.
// Input is held off during a traverse and while the output register is full and not taken.
// rst_n (synchronous) empties the list; entry data is not cleared.
`default_nettype none
`include "descending_sorted_list_top_macros.svh"
module descending_sorted_list_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire dsl_pkg::in_beat_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output dsl_pkg::out_beat_t      out_data
);

  dsl_pkg::state_t             state_r, state_nxt;
  logic [dsl_pkg::IDX_W-1:0]   cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  dsl_pkg::out_beat_t          out_r, out_nxt;

  dsl_pkg::cell_ctrl_t         ctrl;
  dsl_pkg::chain_stat_t        stat;
  logic [dsl_pkg::DEPTH-1:0]   vld;
  dsl_pkg::word_t              rd_data;
  logic                        rd_last;
  logic                        acc, out_free;

  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (state_r == dsl_pkg::S_IDLE) && out_free;
  assign acc        = in_valid && in_ready;

  assign ctrl.value = in_data.value;
  assign ctrl.ins   = acc && (in_data.cmd == dsl_pkg::CMD_INSERT) && !stat.full;
  assign ctrl.del   = acc && (in_data.cmd == dsl_pkg::CMD_DELETE);

  dsl_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .rd_idx  (cnt_r),
    .stat    (stat),
    .vld     (vld),
    .rd_data (rd_data),
    .rd_last (rd_last)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      dsl_pkg::S_IDLE: begin
        if (acc) begin
          out_nxt.item = in_data.value;
          out_nxt.last = 1'b1;
          case (in_data.cmd)
            dsl_pkg::CMD_INSERT: begin
              out_valid_nxt  = 1'b1;
              out_nxt.status = stat.full ? dsl_pkg::ST_FULL : dsl_pkg::ST_OK;
            end
            dsl_pkg::CMD_DELETE: begin
              out_valid_nxt  = 1'b1;
              if (stat.empty) begin
                out_nxt.status = dsl_pkg::ST_EMPTY;
              end else if (stat.found) begin
                out_nxt.status = dsl_pkg::ST_OK;
              end else begin
                out_nxt.status = dsl_pkg::ST_NOTFOUND;
              end
            end
            dsl_pkg::CMD_TRAVERSE: begin
              if (stat.empty) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = dsl_pkg::ST_EMPTY;
                out_nxt.item   = '0;
              end else begin
                state_nxt = dsl_pkg::S_TRAV;
                cnt_nxt   = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      dsl_pkg::S_TRAV: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = dsl_pkg::ST_OK;
          out_nxt.item   = rd_data;
          out_nxt.last   = rd_last;
          cnt_nxt        = cnt_r + 1'b1;
          if (rd_last) begin
            state_nxt = dsl_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = dsl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dsl_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // occupancy is a thermometer code: no valid cell after an empty one
  `DSL_ASSERT_SAME(a_vld_thermo, 1'b1, ((vld >> 1) & ~vld) == '0, "valid bits have a hole")
  // an accepted insert into a non-full list grows the list by one
  `DSL_ASSERT_NEXT(a_ins_grow, ctrl.ins,
    $countones(vld) == $countones($past(vld)) + 1, "insert did not add one entry")
  // a dropped insert leaves the list untouched
  `DSL_ASSERT_NEXT(a_full_hold, acc && (in_data.cmd == dsl_pkg::CMD_INSERT) && stat.full,
    $stable(vld), "full insert changed occupancy")

endmodule
`default_nettype wire
